@@ src/gpps_pkg.sv @@
// ----------------------------------------------------------------------------
// Gaussian point path smoother package
// Shared constants, state type and the kernel weight tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpps_pkg;

  // Geometry and number formats.
  localparam int MaxHalfWindow  = 12;
  localparam int CoordW         = 16;
  localparam int WeightFracBits = 16;

  localparam int WinDepth = 2 * MaxHalfWindow + 1;
  localparam int HalfW    = $clog2(MaxHalfWindow + 1);
  localparam int WinIdxW  = HalfW + 1;

  // Stored weights are Q0.16; they are rescaled to WeightFracBits.
  localparam int RomW        = 16;
  localparam int WeightUp    = (WeightFracBits > RomW) ? (WeightFracBits - RomW) : 0;
  localparam int WeightDown  = (WeightFracBits < RomW) ? (RomW - WeightFracBits) : 0;
  localparam int WeightW     = RomW + WeightUp;

  // Product of a signed coordinate and a zero-extended weight, and the sum.
  localparam int ProdW = CoordW + WeightW + 1;
  localparam int AccW  = ProdW + 1;

  // Configuration port.
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic RegKernelMode = 1'b0;

  // Kernel selection codes.
  localparam logic KernelWide   = 1'b0;
  localparam logic KernelNarrow = 1'b1;
  localparam int   HalfWide     = 12;
  localparam int   HalfNarrow   = 6;

  localparam logic [RomW-1:0] RomWide [13] = '{
    16'd3478, 16'd3456, 16'd3392, 16'd3289, 16'd3150, 16'd2983, 16'd2784,
    16'd2570, 16'd2342, 16'd2109, 16'd1876, 16'd1648, 16'd1430
  };
  localparam logic [RomW-1:0] RomNarrow [7] = '{
    16'd7290, 16'd7065, 16'd6432, 16'd5502, 16'd4421, 16'd3337, 16'd2366
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MAC,
    S_DRAIN,
    S_EMIT,
    S_FLUSH
  } gpps_state_e;

  // Half window of the selected kernel, limited to the window storage.
  function automatic logic [HalfW-1:0] half_width(logic mode);
    int h;
    h = (mode == KernelNarrow) ? HalfNarrow : HalfWide;
    if (h > MaxHalfWindow) h = MaxHalfWindow;
    return HalfW'(h);
  endfunction

  // Weight of the tap at distance k from the center.
  function automatic logic [WeightW-1:0] tap_weight(logic mode, logic [HalfW-1:0] k);
    int unsigned      kk;
    logic [3:0]       kw;
    logic [2:0]       kn;
    logic [WeightW-1:0] r;
    kk = k;
    kw = 4'((kk > 12) ? 12 : kk);
    kn = 3'((kk > 6) ? 6 : kk);
    if (mode == KernelNarrow) r = WeightW'(RomNarrow[kn]);
    else r = WeightW'(RomWide[kw]);
    return (r << WeightUp) >> WeightDown;
  endfunction

endpackage

@@ src/gpps_point_if.sv @@
// ----------------------------------------------------------------------------
// Path point channel
// Valid/ready channel that carries one input path point per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpps_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [gpps_pkg::CoordW-1:0]  point_x;
  logic signed [gpps_pkg::CoordW-1:0]  point_y;
  logic                                is_last;

  modport source (output valid, output point_x, output point_y, output is_last, input ready);
  modport sink   (input valid, input point_x, input point_y, input is_last, output ready);
endinterface

@@ src/gpps_smooth_if.sv @@
// ----------------------------------------------------------------------------
// Smoothed point channel
// Valid/ready channel that carries one smoothed path point per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpps_smooth_if;
  logic                                valid;
  logic                                ready;
  logic signed [gpps_pkg::CoordW-1:0]  smooth_x;
  logic signed [gpps_pkg::CoordW-1:0]  smooth_y;
  logic                                path_end;

  modport source (output valid, output smooth_x, output smooth_y, output path_end, input ready);
  modport sink   (input valid, input smooth_x, input smooth_y, input path_end, output ready);
endinterface

@@ src/gaussian_point_path_smoother.sv @@
// ----------------------------------------------------------------------------
// Gaussian point path smoother
// Sequence: S_IDLE takes a point; S_CHECK decides whether it completes a window;
//   S_MAC runs one multiply-accumulate pair per tap, S_DRAIN adds the last product
//   and S_EMIT loads the output register. A new point is taken only in S_IDLE, once
//   the previous one is through. After a last point, S_FLUSH pushes the last point
//   again and releases each owed result through the same steps.
// Reset: asynchronous, active low; clears the sequencer, counters and kernel
//   select. The window needs no reset, since the first point of a path fills it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_point_path_smoother (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gpps_point_if.sink                      point_i,
  gpps_smooth_if.source                   smooth_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gpps_pkg::AddrW-1:0]      paddr,
  input  logic [gpps_pkg::DataW-1:0]      pwdata,
  output logic [gpps_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  localparam int CoordW  = gpps_pkg::CoordW;
  localparam int HalfW   = gpps_pkg::HalfW;
  localparam int WinIdxW = gpps_pkg::WinIdxW;
  localparam int ProdW   = gpps_pkg::ProdW;
  localparam int AccW    = gpps_pkg::AccW;
  localparam int Wfb     = gpps_pkg::WeightFracBits;
  localparam int QW      = AccW - Wfb;
  localparam int SumW    = HalfW + 2;

  localparam logic [AccW-1:0] RoundHalf = AccW'(64'd1 << (Wfb - 1));
  localparam logic [QW-1:0]   QHi       = QW'((64'd1 << (CoordW - 1)) - 64'd1);
  localparam logic [QW-1:0]   QLoMag    = QW'(64'd1 << (CoordW - 1));

  // --------------------------------------------------------------------------
  // Rounding: the sum is scaled by 2^Wfb. Its magnitude is rounded half away
  // from zero and the signed result is saturated to the coordinate range.
  // --------------------------------------------------------------------------
  function automatic logic [CoordW-1:0] round_sat(logic signed [AccW-1:0] acc);
    logic [AccW-1:0]   mag;
    logic [AccW-1:0]   rnd;
    logic [QW-1:0]     q;
    logic [CoordW-1:0] res;
    mag = acc[AccW-1] ? $unsigned(-acc) : $unsigned(acc);
    rnd = mag + RoundHalf;
    q   = rnd[AccW-1:Wfb];
    if (acc[AccW-1]) begin
      if (q > QLoMag) res = {1'b1, {(CoordW - 1){1'b0}}};
      else res = CoordW'(QW'(0) - q);
    end else begin
      if (q > QHi) res = {1'b0, {(CoordW - 1){1'b1}}};
      else res = CoordW'(q);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register. Only the kernel select exists; it sits at byte
  // address 0 (only paddr[2] is decoded), and writes with paddr[2] set are dropped.
  // --------------------------------------------------------------------------
  logic kernel_mode_q, kernel_mode_d;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == gpps_pkg::RegKernelMode);

  always_comb begin
    kernel_mode_d = kernel_mode_q;
    if (cfg_write) begin
      kernel_mode_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == gpps_pkg::RegKernelMode) begin
      prdata = {{(gpps_pkg::DataW - 1){1'b0}}, kernel_mode_q};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and item context.
  // pend_q counts points taken in whose smoothed result is still owed. pad_q
  // counts replicated copies of the last point pushed during a flush.
  // --------------------------------------------------------------------------
  gpps_pkg::gpps_state_e state_q, state_d;
  logic [WinIdxW-1:0] pend_q, pend_d;
  logic [WinIdxW-1:0] pad_q, pad_d;
  logic [HalfW-1:0]   h_q, h_d;
  logic               mode_q, mode_d;
  logic               last_q, last_d;
  logic               end_q, end_d;
  logic [WinIdxW-1:0] cnt_q, cnt_d;

  // The window: a shift line of points, newest at index 0.
  logic signed [CoordW-1:0] win_x_q [gpps_pkg::WinDepth];
  logic signed [CoordW-1:0] win_y_q [gpps_pkg::WinDepth];
  logic                     win_fill;
  logic                     win_shift;
  logic signed [CoordW-1:0] win_new_x;
  logic signed [CoordW-1:0] win_new_y;

  // Shared multiply-accumulate unit, one lane for x and one for y.
  logic signed [ProdW-1:0] prod_x_q, prod_y_q;
  logic signed [AccW-1:0]  acc_x_q, acc_x_d;
  logic signed [AccW-1:0]  acc_y_q, acc_y_d;
  logic [WinIdxW-1:0]      tap_dist;
  logic [gpps_pkg::WeightW-1:0] tap_w;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic                     out_load;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic                     out_end_q;

  logic [WinIdxW-1:0] two_h;
  logic [SumW-1:0]    pend_pad;

  assign two_h    = {h_q, 1'b0};
  assign pend_pad = SumW'(pend_q) + SumW'(pad_q);

  // The tap index runs over the window from 0 to 2h; its weight depends on
  // the distance to the center at index h.
  assign tap_dist = (cnt_q >= WinIdxW'(h_q)) ? (cnt_q - WinIdxW'(h_q))
                                              : (WinIdxW'(h_q) - cnt_q);
  assign tap_w    = gpps_pkg::tap_weight(mode_q, tap_dist[HalfW-1:0]);

  // --------------------------------------------------------------------------
  // Next state and control.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    pad_d     = pad_q;
    h_d       = h_q;
    mode_d    = mode_q;
    last_d    = last_q;
    end_d     = end_q;
    cnt_d     = cnt_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    win_fill  = 1'b0;
    win_shift = 1'b0;
    win_new_x = point_i.point_x;
    win_new_y = point_i.point_y;
    out_load  = 1'b0;
    point_i.ready = 1'b0;

    case (state_q)
      gpps_pkg::S_IDLE: begin
        point_i.ready = 1'b1;
        if (point_i.valid) begin
          // A path starts when nothing is owed: the whole window takes the
          // point, which replicates the first point before the path.
          if (pend_q == '0) win_fill = 1'b1;
          else win_shift = 1'b1;
          pend_d  = pend_q + 1'b1;
          pad_d   = '0;
          last_d  = point_i.is_last;
          h_d     = gpps_pkg::half_width(kernel_mode_q);
          mode_d  = kernel_mode_q;
          state_d = gpps_pkg::S_CHECK;
        end
      end

      gpps_pkg::S_CHECK: begin
        if (pend_q > WinIdxW'(h_q)) begin
          pend_d  = pend_q - 1'b1;
          end_d   = 1'b0;
          cnt_d   = '0;
          state_d = gpps_pkg::S_MAC;
        end else if (last_q) begin
          state_d = gpps_pkg::S_FLUSH;
        end else begin
          state_d = gpps_pkg::S_IDLE;
        end
      end

      gpps_pkg::S_MAC: begin
        // The product of the previous tap is added here; the first tap
        // clears the sum instead.
        if (cnt_q == '0) begin
          acc_x_d = '0;
          acc_y_d = '0;
        end else begin
          acc_x_d = acc_x_q + AccW'(prod_x_q);
          acc_y_d = acc_y_q + AccW'(prod_y_q);
        end
        if (cnt_q == two_h) begin
          state_d = gpps_pkg::S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      gpps_pkg::S_DRAIN: begin
        acc_x_d = acc_x_q + AccW'(prod_x_q);
        acc_y_d = acc_y_q + AccW'(prod_y_q);
        state_d = gpps_pkg::S_EMIT;
      end

      gpps_pkg::S_EMIT: begin
        if (!out_valid_q || smooth_o.ready) begin
          out_load = 1'b1;
          state_d  = last_q ? gpps_pkg::S_FLUSH : gpps_pkg::S_IDLE;
        end
      end

      gpps_pkg::S_FLUSH: begin
        // Past the end of the path the last point is pushed again, once per cycle
        // in S_FLUSH, until every owed result has its window; each released result is computed first.
        if (pend_q == '0) begin
          state_d = gpps_pkg::S_IDLE;
        end else begin
          win_shift = 1'b1;
          win_new_x = win_x_q[0];
          win_new_y = win_y_q[0];
          pad_d     = pad_q + 1'b1;
          if (pend_pad >= SumW'(h_q)) begin
            pend_d  = pend_q - 1'b1;
            end_d   = (pend_q == WinIdxW'(1));
            cnt_d   = '0;
            state_d = gpps_pkg::S_MAC;
          end
        end
      end

      default: begin
        state_d = gpps_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (smooth_o.ready) out_valid_d = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= gpps_pkg::S_IDLE;
      pend_q        <= '0;
      pad_q         <= '0;
      h_q           <= '0;
      mode_q        <= gpps_pkg::KernelWide;
      last_q        <= 1'b0;
      end_q         <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      kernel_mode_q <= gpps_pkg::KernelWide;
    end else begin
      state_q       <= state_d;
      pend_q        <= pend_d;
      pad_q         <= pad_d;
      h_q           <= h_d;
      mode_q        <= mode_d;
      last_q        <= last_d;
      end_q         <= end_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      kernel_mode_q <= kernel_mode_d;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers: window, products, sums and the result.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (win_fill) begin
      for (int i = 0; i < gpps_pkg::WinDepth; i++) begin
        win_x_q[i] <= win_new_x;
        win_y_q[i] <= win_new_y;
      end
    end else if (win_shift) begin
      win_x_q[0] <= win_new_x;
      win_y_q[0] <= win_new_y;
      for (int i = 1; i < gpps_pkg::WinDepth; i++) begin
        win_x_q[i] <= win_x_q[i-1];
        win_y_q[i] <= win_y_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= win_x_q[cnt_q] * $signed({1'b0, tap_w});
    prod_y_q <= win_y_q[cnt_q] * $signed({1'b0, tap_w});
    acc_x_q  <= acc_x_d;
    acc_y_q  <= acc_y_d;
    if (out_load) begin
      out_x_q   <= round_sat(acc_x_q);
      out_y_q   <= round_sat(acc_y_q);
      out_end_q <= end_q;
    end
  end

  assign smooth_o.valid    = out_valid_q;
  assign smooth_o.smooth_x = out_x_q;
  assign smooth_o.smooth_y = out_y_q;
  assign smooth_o.path_end = out_end_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // Between items the owed count never exceeds the largest half window, MaxHalfWindow.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gpps_pkg::S_IDLE |-> pend_q <= WinIdxW'(gpps_pkg::MaxHalfWindow))
    else $error("owed result count out of range");

  // The tap counter stays inside the kernel while the sums run.
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gpps_pkg::S_MAC |-> cnt_q <= two_h)
    else $error("tap index beyond kernel");

  // A finished flush leaves nothing owed, so the next point starts a path.
  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gpps_pkg::S_FLUSH && pend_q == '0)
      |=> (state_q == gpps_pkg::S_IDLE && pend_q == '0))
    else $error("flush did not return to an empty path");

  // The end-of-path mark is only produced while flushing a path.
  a_end_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && end_q |-> last_q && pend_q == '0)
    else $error("path end marked outside a flush");

endmodule

@@ tb/sv/gaussian_point_path_smoother_tb.sv @@
// ----------------------------------------------------------------------------
// Gaussian point path smoother testbench
// Drives paths of signed 2-D points into the smoother. A scoreboard predicts
// every smoothed point from its own window and weight tables and checks each
// output transfer field by field. Both kernels, mid-path kernel changes,
// extreme coordinates, random stalls and a long output back-pressure stretch
// are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_point_path_smoother_tb;
  import gpps_pkg::*;

  // Clock and run length.
  localparam int ClkHalfNs    = 4;
  localparam int SettleCycles = 64;     // comfortably above the block's latency
  localparam int HoldOffCycles = 300;   // long enough to fill the block up
  localparam longint LimitNs  = 4_000_000;
  localparam int PhaseItems   = 10;

  localparam logic [AddrW-1:0] KernelAddr = AddrW'(4 * RegKernelMode);

  localparam int CoordMax = 2 ** (CoordW - 1) - 1;
  localparam int FracBits = 16;

  // Q0.16 tap weights by distance from the center tap; each table sums to
  // 65536 over the full symmetric window.
  localparam int WideTaps [13] = '{
    3478, 3456, 3392, 3289, 3150, 2983, 2784, 2570, 2342, 2109, 1876, 1648, 1430
  };
  localparam int NarrowTaps [7] = '{7290, 7065, 6432, 5502, 4421, 3337, 2366};

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } smooth_pt_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the point window and the path counters,
  // turns every accepted input point into the smoothed points that it
  // releases, and checks output transfers against them in order.
  // --------------------------------------------------------------------------
  class path_smooth_scoreboard;
    logic signed [CoordW-1:0] win_x [WinDepth];
    logic signed [CoordW-1:0] win_y [WinDepth];
    logic [15:0]              seen_cnt;
    logic [15:0]              out_cnt;
    logic                     kernel;
    smooth_pt_t               due_points [$];
    int                       errors;

    function new();
      seen_cnt = '0;
      out_cnt  = '0;
      kernel   = KernelWide;
      errors   = 0;
      foreach (win_x[i]) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
    endfunction

    function longint tap(int k);
      if (kernel == KernelNarrow) return NarrowTaps[k];
      return WideTaps[k];
    endfunction

    // Divide by 2^16, rounding half away from zero, then clamp to 16 bits.
    function logic signed [CoordW-1:0] round_sat(longint acc);
      longint mag;
      longint q;
      mag = (acc < 0) ? -acc : acc;
      q   = (mag + (longint'(1) << (FracBits - 1))) >>> FracBits;
      if (acc < 0) return (q > CoordMax + 1) ? CoordW'(-CoordMax - 1) : CoordW'(-q);
      return (q > CoordMax) ? CoordW'(CoordMax) : CoordW'(q);
    endfunction

    function void shift_in(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y);
      for (int i = WinDepth - 1; i > 0; i--) begin
        win_x[i] = win_x[i-1];
        win_y[i] = win_y[i-1];
      end
      win_x[0] = x;
      win_y[0] = y;
    endfunction

    // The output point sits h entries back from the newest one.
    function void emit(int h, logic last);
      longint     acc_x;
      longint     acc_y;
      longint     w;
      smooth_pt_t p;
      acc_x = 0;
      acc_y = 0;
      for (int d = -h; d <= h; d++) begin
        w = tap((d < 0) ? -d : d);
        acc_x += w * longint'(win_x[h + d]);
        acc_y += w * longint'(win_y[h + d]);
      end
      p.x    = round_sat(acc_x);
      p.y    = round_sat(acc_y);
      p.last = last;
      due_points = {due_points, p};
    endfunction

    function void take_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                             logic last);
      int unsigned waiting;
      int          h;
      int          n;
      int unsigned pad;
      waiting = 16'(seen_cnt - out_cnt);
      h = (kernel == KernelNarrow) ? HalfNarrow : HalfWide;
      n = 0;
      // The first point of a path stands in for everything before it.
      if (waiting == 0) begin
        foreach (win_x[i]) begin
          win_x[i] = x;
          win_y[i] = y;
        end
      end else begin
        shift_in(x, y);
      end
      seen_cnt++;
      waiting++;
      if (waiting > h) begin
        waiting--;
        out_cnt++;
        emit(h, 1'b0);
        n++;
      end
      // Flush: the last point is repeated until every held point is out.
      if (last) begin
        pad = 0;
        while (waiting > 0 && n < 13) begin
          shift_in(win_x[0], win_y[0]);
          pad++;
          if (waiting - 1 + pad >= h) begin
            waiting--;
            emit(h, waiting == 0);
            n++;
          end
        end
        seen_cnt = '0;
        out_cnt  = '0;
      end
    endfunction

    function void check_smoothed(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                                 logic last);
      smooth_pt_t e;
      if (due_points.size() == 0) begin
        $display("%0t: unexpected smoothed point x=%0d y=%0d path_end=%0b",
                 $time, x, y, last);
        errors++;
        return;
      end
      e = due_points.pop_front();
      if (x !== e.x) begin
        $display("%0t: smooth_x mismatch, expected %0d, got %0d", $time, e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: smooth_y mismatch, expected %0d, got %0d", $time, e.y, y);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: path_end mismatch, expected %0b, got %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always #(ClkHalfNs) clk_i = ~clk_i;

  gpps_point_if  pt_if ();
  gpps_smooth_if sm_if ();

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  gaussian_point_path_smoother dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pt_if),
    .smooth_o (sm_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  path_smooth_scoreboard path_sb;

  // Random idling is on for both sides except in one quiet phase. The hold-off
  // request makes the receiver refuse output for a long counted stretch.
  logic gaps_on;
  logic hold_off_req;

  // --------------------------------------------------------------------------
  // Monitor: every transfer is seen at the rising edge, before the block
  // updates, so the values taken are the ones that were transferred.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pt_if.valid && pt_if.ready)
        path_sb.take_point(pt_if.point_x, pt_if.point_y, pt_if.is_last);
      if (sm_if.valid && sm_if.ready)
        path_sb.check_smoothed(sm_if.smooth_x, sm_if.smooth_y, sm_if.path_end);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge only. A hold-off is counted
  // here, so the sender keeps offering points while the block fills up.
  // --------------------------------------------------------------------------
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    sm_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        sm_if.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        sm_if.ready <= !(gaps_on && $urandom_range(99) < 18);
      end
    end
  end

  // Ends a run that hangs.
  initial begin
    #(LimitNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks.
  // --------------------------------------------------------------------------

  // Offers one point and returns at the edge where it is transferred. Valid
  // stays high afterwards, so it does not drop between back-to-back points.
  task automatic send_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                            logic last);
    if (gaps_on && $urandom_range(99) < 18) begin
      @(negedge clk_i);
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.is_last <= last;
    do @(posedge clk_i); while (!pt_if.ready);
  endtask

  // Stops offering points and waits until every predicted point is out, then
  // a little longer, since points that release no output may still be in work.
  task automatic drain_smoother();
    @(negedge clk_i);
    pt_if.valid <= 1'b0;
    while (path_sb.due_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [AddrW-1:0] addr, output logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called while the block is idle; the register is read back as well.
  task automatic write_kernel(logic mode);
    logic [DataW-1:0] rd;
    apb_write(KernelAddr, DataW'(mode));
    path_sb.kernel = mode;
    apb_read(KernelAddr, rd);
    if (rd[0] !== mode) begin
      $display("%0t: kernel_mode readback mismatch, expected %0b, got %0b",
               $time, mode, rd[0]);
      path_sb.errors++;
    end
  endtask

  function automatic logic signed [CoordW-1:0] edge_coord();
    case ($urandom_range(3))
      0:       return CoordW'(-CoordMax - 1);
      1:       return CoordW'(CoordMax);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Sends one path. Style 0 is white noise over the whole range, style 1 a
  // random walk (the realistic case, wrapping across the extremes at times),
  // style 2 jumps between the extremes, zero and minus one. Now and then the kernel is swapped
  // part way through the path, once the block has gone quiet.
  task automatic send_path(int len, int style, bit may_flip);
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    int                       flip_at;
    x = CoordW'($urandom);
    y = CoordW'($urandom);
    flip_at = -1;
    if (may_flip && len > 1 && $urandom_range(9) == 0)
      flip_at = $urandom_range(len - 1, 1);
    for (int i = 0; i < len; i++) begin
      if (i == flip_at) begin
        drain_smoother();
        write_kernel(~path_sb.kernel);
      end
      case (style)
        0: begin
          x = CoordW'($urandom);
          y = CoordW'($urandom);
        end
        1: begin
          x = x + CoordW'($urandom_range(80)) - CoordW'(40);
          y = y + CoordW'($urandom_range(80)) - CoordW'(40);
        end
        default: begin
          x = edge_coord();
          y = edge_coord();
        end
      endcase
      send_point(x, y, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    int len;

    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.is_last = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    path_sb       = new();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A path of one point must come back unchanged.
    write_kernel(KernelWide);
    send_point(CoordW'(CoordMax), CoordW'(-CoordMax - 1), 1'b1);

    // A path shorter than the half window is released entirely by the flush.
    send_point(CoordW'(-CoordMax - 1), CoordW'(CoordMax), 1'b0);
    send_point('0, '0, 1'b0);
    send_point('1, CoordW'(1), 1'b1);

    // Narrow kernel on alternating extremes: the sums go as far as they can.
    drain_smoother();
    write_kernel(KernelNarrow);
    for (int i = 0; i < 6; i++)
      send_point((i % 2) ? CoordW'(CoordMax) : CoordW'(-CoordMax - 1),
                 (i % 2) ? CoordW'(-CoordMax - 1) : CoordW'(CoordMax), i == 5);

    // Kernel widened in the middle of a path, while points are held.
    for (int i = 0; i < 4; i++)
      send_point(CoordW'(i * 1000), CoordW'(-i * 777), 1'b0);
    drain_smoother();
    write_kernel(KernelWide);
    for (int i = 4; i < 7; i++)
      send_point(CoordW'(i * 1000), CoordW'(-i * 777), i == 6);

    // Kernel narrowed with more points held than the new half window.
    for (int i = 0; i < 9; i++)
      send_point(CoordW'(CoordMax - i * 3001), CoordW'(i * 2999 - CoordMax), 1'b0);
    drain_smoother();
    write_kernel(KernelNarrow);
    send_point(CoordW'(-5), CoordW'(5), 1'b1);

    // Random part in phases, each under its own kernel setting. Phase 2 runs
    // without any idling; phase 3 opens with a long full path while the
    // receiver holds off, so the block has to stall its input.
    for (int phase = 0; phase < 6; phase++) begin
      drain_smoother();
      case (phase)
        0:       write_kernel(KernelWide);
        1:       write_kernel(KernelNarrow);
        3:       write_kernel(KernelWide);
        default: write_kernel(logic'($urandom_range(1)));
      endcase
      gaps_on = (phase != 2);
      sent = 0;
      if (phase == 3) begin
        hold_off_req = 1'b1;
        send_path(30, 1, 1'b0);
        sent = 30;
      end
      while (sent < PhaseItems) begin
        len = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : $urandom_range(30, 4);
        send_path(len, ($urandom_range(99) < 60) ? 1 : $urandom_range(2), 1'b1);
        sent += len;
      end
    end

    gaps_on = 1'b1;
    drain_smoother();

    if (path_sb.errors == 0 && path_sb.due_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ gaussian_point_path_smoother.f @@
src/gpps_pkg.sv
src/gpps_point_if.sv
src/gpps_smooth_if.sv
src/gaussian_point_path_smoother.sv
tb/sv/gaussian_point_path_smoother_tb.sv
